// ===== hw/rtl/opad_pkg.sv =====
// ----------------------------------------------------------------------------
// OOK PWM decoder package
// Shared types and constants for the autobaud pulse-width decoder.
// ----------------------------------------------------------------------------
package opad_pkg;

    localparam int unsigned MaxPulsesDef = 512;
    localparam int unsigned MinBitsDef   = 16;
    localparam int unsigned MaxBitsDef   = 64;

    localparam logic [15:0] MinPulseRst = 16'd100;
    localparam logic [15:0] GapLimitRst = 16'd5000;
    localparam logic [6:0]  TolRst      = 7'd30;
    localparam logic [7:0]  TagRst      = 8'd0;

    localparam logic [1:0] RegMinPulse = 2'd0;
    localparam logic [1:0] RegGapLimit = 2'd1;
    localparam logic [1:0] RegTol      = 2'd2;
    localparam logic [1:0] RegTag      = 2'd3;

    typedef struct packed {
        logic [15:0] pulse_time;
        logic        last;
    } in_word_t;

    typedef struct packed {
        logic        status;
        logic [63:0] code;
        logic [6:0]  bit_count;
        logic [15:0] base_time;
        logic [7:0]  reported_tag;
    } out_word_t;

endpackage

// ===== hw/rtl/ook_pwm_autobaud_decoder.sv =====
// ----------------------------------------------------------------------------
// OOK PWM autobaud decoder
// Stores packet pulses, finds base time, decodes PWM pairs at 1:3 then 1:2.
// ----------------------------------------------------------------------------
// A non-last word is stored in the pulse memory while it has room. A last word
// starts a scan for the shortest pulse, then up to two decode passes over
// the pulse pairs, all through one shared tolerance compare unit and a pulse
// memory with one read port. Not ready while a packet is analyzed or a result
// waits. Reset clears control state and restores register defaults; the
// pulse memory is not cleared.
module ook_pwm_autobaud_decoder
#(
    parameter int unsigned MAX_PULSES = opad_pkg::MaxPulsesDef,
    parameter int unsigned MIN_BITS   = opad_pkg::MinBitsDef,
    parameter int unsigned MAX_BITS   = opad_pkg::MaxBitsDef
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  opad_pkg::in_word_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output opad_pkg::out_word_t  out_data,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_wdata
);
    import opad_pkg::*;

    localparam int AW = $clog2(MAX_PULSES);
    localparam int CW = AW + 1;

    typedef enum logic [3:0] {
        S_COLLECT, S_SCAN_RD, S_SCAN, S_CHECK, S_PASS_INIT, S_RD_A, S_RD_B,
        S_CMP, S_BIT, S_PASS_END, S_OUT
    } state_t;

    state_t state_reg;
    logic [15:0] min_reg, gap_reg;
    logic [6:0]  tol_reg;
    logic [7:0]  tag_reg;

    logic [15:0] mem [MAX_PULSES];
    logic [15:0] rdata_reg;
    logic [AW-1:0] raddr;

    logic [CW-1:0] cnt_reg, idx_reg;
    logic [15:0] shortest_reg;
    logic        found_reg;
    logic [63:0] code_reg;
    logic [6:0]  bits_reg;
    logic        pass_reg;
    logic [15:0] a_reg, b_reg;
    logic [1:0]  step_reg;      // compare step 0..3
    logic [2:0]  hit_reg;       // b~l, a~l, b~s
    out_word_t   out_reg;
    logic        outv_reg;

    // shared tolerance unit: |t - n| < (n*tol)/100
    logic [17:0] nom;
    logic [15:0] cmp_t;
    logic [24:0] prod;
    logic [18:0] diff;
    logic [24:0] scaled;
    logic        near;
    always_comb
    begin
        nom   = (step_reg[0] ^ step_reg[1]) ?
                ({2'b0, shortest_reg} * (pass_reg ? 18'd2 : 18'd3)) : {2'b0, shortest_reg};
        cmp_t = step_reg[0] ? b_reg : a_reg;
        prod  = 25'(nom) * 25'(tol_reg);
        diff  = ({3'b0, cmp_t} > {1'b0, nom}) ? ({3'b0, cmp_t} - {1'b0, nom})
                                              : ({1'b0, nom} - {3'b0, cmp_t});
        // d < floor(p/100) holds exactly when 100*(d+1) <= p
        scaled = (25'(diff) + 25'd1) * 25'd100;
        near   = scaled <= prod;
    end

    assign in_ready  = (state_reg == S_COLLECT) && !outv_reg;
    assign out_valid = outv_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        raddr = idx_reg[AW-1:0];
        if (state_reg == S_RD_B)
            raddr = AW'(idx_reg + CW'(1));
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready && (cnt_reg < CW'(MAX_PULSES)))
            mem[cnt_reg[AW-1:0]] <= in_data.pulse_time;
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_COLLECT;
            min_reg      <= MinPulseRst;
            gap_reg      <= GapLimitRst;
            tol_reg      <= TolRst;
            tag_reg      <= TagRst;
            cnt_reg      <= '0;
            idx_reg      <= '0;
            shortest_reg <= 16'hFFFF;
            found_reg    <= 1'b0;
            code_reg     <= '0;
            bits_reg     <= '0;
            pass_reg     <= 1'b0;
            step_reg     <= '0;
            hit_reg      <= '0;
            outv_reg     <= 1'b0;
            a_reg        <= '0;
            b_reg        <= '0;
            out_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    RegMinPulse: min_reg <= cfg_wdata;
                    RegGapLimit: gap_reg <= cfg_wdata;
                    RegTol:      tol_reg <= cfg_wdata[6:0];
                    RegTag:      tag_reg <= cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (outv_reg && out_ready)
                outv_reg <= 1'b0;
            case (state_reg)
                S_COLLECT:
                begin
                    if (in_valid && in_ready)
                    begin
                        if (cnt_reg < CW'(MAX_PULSES))
                            cnt_reg <= cnt_reg + CW'(1);
                        if (in_data.last)
                        begin
                            idx_reg      <= '0;
                            found_reg    <= 1'b0;
                            shortest_reg <= 16'hFFFF;
                            pass_reg     <= 1'b0;
                            state_reg    <= S_SCAN_RD;
                        end
                    end
                end
                S_SCAN_RD:
                begin
                    // skip the scan for a short packet, else start reading
                    if (cnt_reg < CW'(2 * MIN_BITS))
                        state_reg <= S_CHECK;
                    else
                    begin
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    // rdata holds entry idx-1
                    if (rdata_reg >= min_reg && (!found_reg || rdata_reg < shortest_reg))
                    begin
                        shortest_reg <= rdata_reg;
                        found_reg    <= 1'b1;
                    end
                    if (idx_reg + CW'(1) < cnt_reg)
                        idx_reg <= idx_reg + CW'(1);
                    else
                        state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (cnt_reg < CW'(2 * MIN_BITS) || !found_reg || shortest_reg >= gap_reg)
                        state_reg <= S_PASS_END;
                    else
                        state_reg <= S_PASS_INIT;
                end
                S_PASS_INIT:
                begin
                    idx_reg   <= '0;
                    code_reg  <= '0;
                    bits_reg  <= '0;
                    state_reg <= S_RD_A;
                end
                S_RD_A:
                begin
                    if (idx_reg + CW'(1) < cnt_reg && bits_reg < 7'(MAX_BITS))
                        state_reg <= S_RD_B;
                    else
                        state_reg <= S_PASS_END;
                end
                S_RD_B:
                begin
                    a_reg     <= rdata_reg;
                    state_reg <= S_CMP;
                    step_reg  <= '0;
                end
                S_CMP:
                begin
                    if (step_reg == 2'd0)
                        b_reg <= rdata_reg;
                    else
                        hit_reg[step_reg - 2'd1] <= near;
                    step_reg <= step_reg + 2'd1;
                    if (step_reg == 2'd3)
                        state_reg <= S_BIT;
                end
                S_BIT:
                begin
                    // last compare (a vs short) lands here from the unit
                    if (near && hit_reg[0])
                    begin
                        code_reg  <= {code_reg[62:0], 1'b0};
                        bits_reg  <= bits_reg + 7'd1;
                        idx_reg   <= idx_reg + CW'(2);
                        state_reg <= S_RD_A;
                    end
                    else if (hit_reg[1] && hit_reg[2])
                    begin
                        code_reg  <= {code_reg[62:0], 1'b1};
                        bits_reg  <= bits_reg + 7'd1;
                        idx_reg   <= idx_reg + CW'(2);
                        state_reg <= S_RD_A;
                    end
                    else
                        state_reg <= S_PASS_END;
                end
                S_PASS_END:
                begin
                    if (found_reg && cnt_reg >= CW'(2 * MIN_BITS) && shortest_reg < gap_reg
                        && !pass_reg && bits_reg < 7'(MIN_BITS))
                    begin
                        pass_reg  <= 1'b1;
                        state_reg <= S_PASS_INIT;
                    end
                    else
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (found_reg && cnt_reg >= CW'(2 * MIN_BITS) && shortest_reg < gap_reg
                        && bits_reg >= 7'(MIN_BITS))
                    begin
                        out_reg.status    <= 1'b0;
                        out_reg.code      <= code_reg;
                        out_reg.bit_count <= bits_reg;
                        out_reg.base_time <= shortest_reg;
                    end
                    else
                    begin
                        out_reg.status    <= 1'b1;
                        out_reg.code      <= '0;
                        out_reg.bit_count <= '0;
                        out_reg.base_time <= '0;
                    end
                    out_reg.reported_tag <= tag_reg;
                    outv_reg  <= 1'b1;
                    cnt_reg   <= '0;
                    bits_reg  <= '0;
                    state_reg <= S_COLLECT;
                end
                default: state_reg <= S_COLLECT;
            endcase
        end
    end

endmodule
